>>> src/dmx_pkg.sv
// Shared types, constants and helpers for the DMX512 frame transmitter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package dmx_pkg;

    // One input request as it arrives on the item channel.
    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] slot_index;
        logic [7:0] slot_value;
    } item_t;

    // One result request as it leaves on the result channel.
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic write_error;
    } result_t;

    // Input mode codes.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [1:0] CFG_BREAK_LEN  = 2'd1;
    localparam logic [1:0] CFG_MAB_LEN    = 2'd2;

    // Register reset values.
    localparam logic [9:0] SLOT_COUNT_RST = 10'd78;
    localparam logic [7:0] BREAK_LEN_RST  = 8'd40;
    localparam logic [4:0] MAB_LEN_RST    = 5'd5;

    // Bit times in one slot: start bit, eight data bits, two stop bits.
    localparam logic [7:0] SLOT_BITS = 8'd11;

    // Depth of the queue between the classifier and the line engine.
    localparam int QUEUE_DEPTH = 2;

    // Operations after classification.
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_WRITE_BAD,
        OP_START,
        OP_TICK,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [8:0] slot_index;
        logic [7:0] slot_value;
    } q_entry_t;

    // Frame phases.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BREAK,
        PH_MAB,
        PH_SLOTS
    } phase_t;

    // Slot count clamped into 1 .. max_slots.
    function automatic logic [9:0] eff_slots(input logic [9:0] cnt, input logic [9:0] max_slots);
        logic [9:0] n;
        n = cnt;
        if (n == 10'd0)
        begin
            n = 10'd1;
        end
        if (n > max_slots)
        begin
            n = max_slots;
        end
        return n;
    endfunction

endpackage

>>> src/dmx_front.sv
// Front end of the DMX512 transmitter: accepts input requests and classifies them.
// Depends on dmx_pkg.
`timescale 1ns / 1ps

module dmx_front #(
    parameter int MAX_SLOTS = 512
) (
    input  dmx_pkg::item_t    item,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [9:0]        slot_count,
    input  logic              q_full,
    input  logic              clearing,
    output logic              push,
    output dmx_pkg::q_entry_t entry
);
    import dmx_pkg::*;

    logic [9:0] eff;

    assign eff        = eff_slots(slot_count, 10'(MAX_SLOTS));
    assign item_stall = clearing || q_full;
    assign push       = item_valid && !item_stall;

    // A write past the slots in use is marked here so the back end only flags it.
    always_comb
    begin
        entry.slot_index = item.slot_index;
        entry.slot_value = item.slot_value;
        unique case (item.mode)
            MODE_WRITE: entry.op = ({1'b0, item.slot_index} >= eff) ? OP_WRITE_BAD : OP_WRITE;
            MODE_START: entry.op = OP_START;
            MODE_TICK:  entry.op = OP_TICK;
            default:    entry.op = OP_NOP;
        endcase
    end

endmodule

>>> src/dmx_queue.sv
// Short request queue between the classifier and the line engine.
// Depends on dmx_pkg.
`timescale 1ns / 1ps

module dmx_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dmx_pkg::q_entry_t entry_in,
    input  logic              pop,
    output logic              q_valid,
    output dmx_pkg::q_entry_t entry_out,
    output logic              q_full
);
    import dmx_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_valid   = (count_reg != '0);
    assign q_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign entry_out = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

>>> src/dmx_back.sv
// Line engine of the DMX512 transmitter: slot store, frame sequencer and result register.
// Depends on dmx_pkg.
`timescale 1ns / 1ps

module dmx_back #(
    parameter int MAX_SLOTS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [9:0]        slot_count,
    input  logic [7:0]        break_length,
    input  logic [4:0]        mab_length,
    input  logic              q_valid,
    input  dmx_pkg::q_entry_t q_entry,
    output logic              q_pop,
    output logic              clearing,
    output logic              result_valid,
    input  logic              result_stall,
    output dmx_pkg::result_t  result
);
    import dmx_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

    logic [7:0]    mem [MAX_SLOTS];

    phase_t        phase_reg, phase_next;
    logic [7:0]    count_reg, count_next;
    logic [8:0]    cur_reg, cur_next;
    logic [10:0]   shift_reg, shift_next;
    logic          line_reg, line_next;
    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg;
    logic [7:0]    rdata_reg;
    logic          byp_hit_reg;
    logic [7:0]    byp_data_reg;

    logic          take, do_item, done, werr;
    logic [9:0]    eff;
    logic [7:0]    cnt_inc, brk_len;
    logic [4:0]    mab_len;
    logic [7:0]    pf_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data;
    logic [8:0]    next_slot;

    assign clearing     = clr_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign take    = res_valid_reg && !result_stall;
    assign do_item = q_valid && !clr_reg && (!res_valid_reg || take);
    assign q_pop   = do_item;

    assign eff     = eff_slots(slot_count, 10'(MAX_SLOTS));
    assign cnt_inc = count_reg + 8'd1;
    assign brk_len = (break_length == 8'd0) ? 8'd1 : break_length;
    assign mab_len = (mab_length == 5'd0) ? 5'd1 : mab_length;

    // Level of the next slot to load, with any write of the previous cycle forwarded.
    assign pf_data = byp_hit_reg ? byp_data_reg : rdata_reg;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        done       = 1'b0;
        werr       = 1'b0;
        if (do_item)
        begin
            unique case (q_entry.op)
                OP_WRITE_BAD: werr = 1'b1;
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_BREAK;
                        count_next = 8'd0;
                        cur_next   = 9'd0;
                        line_next  = 1'b0;
                    end
                end
                OP_TICK:
                begin
                    unique case (phase_reg)
                        PH_BREAK:
                        begin
                            count_next = cnt_inc;
                            if (cnt_inc >= brk_len)
                            begin
                                phase_next = PH_MAB;
                                count_next = 8'd0;
                                line_next  = 1'b1;
                            end
                        end
                        PH_MAB:
                        begin
                            count_next = cnt_inc;
                            if (cnt_inc >= {3'b000, mab_len})
                            begin
                                phase_next = PH_SLOTS;
                                cur_next   = 9'd0;
                                shift_next = {2'b11, pf_data, 1'b0};
                                count_next = 8'd0;
                                line_next  = 1'b0;
                            end
                        end
                        PH_SLOTS:
                        begin
                            count_next = cnt_inc;
                            shift_next = {1'b0, shift_reg[10:1]};
                            line_next  = shift_reg[1];
                            if (cnt_inc >= SLOT_BITS)
                            begin
                                if (({1'b0, cur_reg} + 10'd1) >= eff)
                                begin
                                    phase_next = PH_IDLE;
                                    count_next = 8'd0;
                                    cur_next   = 9'd0;
                                    shift_next = 11'd0;
                                    line_next  = 1'b1;
                                    done       = 1'b1;
                                end
                                else
                                begin
                                    cur_next   = cur_reg + 9'd1;
                                    shift_next = {2'b11, pf_data, 1'b0};
                                    count_next = 8'd0;
                                    line_next  = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Store port: the clearing pass owns it after reset, then accepted writes.
    assign wr_en   = clr_reg || (do_item && (q_entry.op == OP_WRITE));
    assign wr_addr = clr_reg ? clr_addr_reg : q_entry.slot_index[AW-1:0];
    assign wr_data = clr_reg ? 8'd0 : q_entry.slot_value;

    // The read always follows the slot that the next load will need.
    assign next_slot = (phase_next == PH_SLOTS) ? (cur_next + 9'd1) : 9'd0;
    assign rd_addr   = next_slot[AW-1:0];

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (do_item)
        begin
            res_valid_next = 1'b1;
        end
        else if (take)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= 8'd0;
            cur_reg       <= 9'd0;
            shift_reg     <= 11'd0;
            line_reg      <= 1'b1;
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            shift_reg     <= shift_next;
            line_reg      <= line_next;
            res_valid_reg <= res_valid_next;
            byp_hit_reg   <= wr_en && (wr_addr == rd_addr);
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= wr_data;
        if (do_item)
        begin
            res_reg.line_level  <= line_next;
            res_reg.busy_res    <= (phase_next != PH_IDLE);
            res_reg.frame_done  <= done;
            res_reg.write_error <= werr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !do_item)
        else $error("request processed during the clearing pass");

    a_done_from_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (do_item && done) |-> (phase_reg == PH_SLOTS))
        else $error("frame finished outside the slot phase");

    a_slot_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SLOTS) |-> (count_reg < SLOT_BITS))
        else $error("slot bit counter overran");

    a_break_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BREAK) |-> !line_reg)
        else $error("line high during break");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_stall) |=> (res_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

>>> src/dmx512_frame_transmitter_unit.sv
// DMX512 frame transmitter: top level with configuration registers.
// Depends on dmx_pkg, dmx_front, dmx_queue and dmx_back.
//
// Usage. Requests enter on the item channel (item, item_valid, item_stall) and each one
// yields exactly one result request on the result channel (result, result_valid,
// result_stall). A request writes one slot level, starts a frame, advances the serial
// line by one bit time, or (mode 3) does nothing; the result reports the line level,
// whether a frame is in progress, the end of a frame and a rejected write.
// Throughput is one request per clock cycle while results are taken and the store is not
// being cleared. A request accepted on the item channel enters the two-entry queue; the
// line engine takes it from the queue head and registers its result in the output
// register for the receiver. The single-port read of the slot store is fetched ahead.
// When the receiver stalls, the finished result waits in the output register and the
// queue absorbs two more requests before item_stall rises.
// After reset the slot store is cleared by a pass over all MAX_SLOTS slots, one slot per
// cycle, during which item_stall is high; configuration writes are taken throughout.
// Configuration (cfg_we, cfg_index, cfg_data) should change only while the block is idle.
`timescale 1ns / 1ps

module dmx512_frame_transmitter_unit #(
    parameter int MAX_SLOTS = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dmx_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_stall,
    output dmx_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [9:0]       cfg_data
);
    import dmx_pkg::*;

    // Configuration registers; an index beyond the list is ignored.
    logic [9:0] slot_count_reg;
    logic [7:0] break_len_reg;
    logic [4:0] mab_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
            break_len_reg  <= BREAK_LEN_RST;
            mab_len_reg    <= MAB_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLOT_COUNT: slot_count_reg <= cfg_data;
                CFG_BREAK_LEN:  break_len_reg  <= cfg_data[7:0];
                CFG_MAB_LEN:    mab_len_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // The front end classifies each request, including the bound check on writes,
    // and hands it to the queue; it stalls while the queue is full or the store clears.
    logic     push, pop, q_valid, q_full, clearing;
    q_entry_t front_entry, back_entry;

    dmx_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .slot_count (slot_count_reg),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .entry      (front_entry)
    );

    dmx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .pop       (pop),
        .q_valid   (q_valid),
        .entry_out (back_entry),
        .q_full    (q_full)
    );

    // The line engine owns the slot store and the frame sequencer, and holds each
    // result in its output register until the receiver takes it.
    dmx_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot_count   (slot_count_reg),
        .break_length (break_len_reg),
        .mab_length   (mab_len_reg),
        .q_valid      (q_valid),
        .q_entry      (back_entry),
        .q_pop        (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
